// File: rtl/sitda_pkg.sv
package sitda_pkg;

  localparam int CHAR_BITS = 6;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

  // decimal digits of 2^(bits-1): floor((bits-1)*log10(2)) + 1
  function automatic int dec_digits(input int bits);
    return ((bits - 1) * 30103) / 100000 + 1;
  endfunction

endpackage

// File: rtl/sitda_value_if.sv
interface sitda_value_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// File: rtl/sitda_char_if.sv
interface sitda_char_if;
  import sitda_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;
  logic                 last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// File: rtl/sitda_dabble.sv
module sitda_dabble #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [VALUE_BITS-1:0] req_value,
  output logic                  bcd_valid,
  input  logic                  bcd_ready,
  output logic [NDIG*4-1:0]     bcd,
  output logic                  neg
);
  localparam int BW    = NDIG * 4;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {IDLE, RUN, HOLD} state_t;

  state_t                  state;
  logic [VALUE_BITS-1:0]   mag;
  logic [CNT_W-1:0]        cnt;
  logic [BW-1:0]           adj;
  logic [VALUE_BITS-1:0]   mag_next;

  assign req_ready = (state == IDLE);
  assign bcd_valid = (state == HOLD);

  assign mag_next = req_value[VALUE_BITS-1] ? (~req_value + VALUE_BITS'(1)) : req_value;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (req_valid) begin
            mag   <= mag_next;
            neg   <= req_value[VALUE_BITS-1];
            bcd   <= '0;
            cnt   <= CNT_W'(VALUE_BITS);
            state <= RUN;
          end
        end
        RUN: begin
          bcd <= {adj[BW-2:0], mag[VALUE_BITS-1]};
          mag <= {mag[VALUE_BITS-2:0], 1'b0};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= HOLD;
          end
        end
        HOLD: begin
          if (bcd_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: rtl/sitda_emit.sv
module sitda_emit #(
  parameter int NDIG = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            bcd_valid,
  output logic                            bcd_ready,
  input  logic [NDIG*4-1:0]               bcd_in,
  input  logic                            neg_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sitda_pkg::CHAR_BITS-1:0] out_char,
  output logic                            out_last
);
  import sitda_pkg::*;

  localparam int BW    = NDIG * 4;
  localparam int CNT_W = $clog2(NDIG + 1);

  typedef enum logic [1:0] {IDLE, SKIP, SIGN, DIGIT} state_t;

  state_t           state;
  logic [BW-1:0]    digits;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic             slot_free;
  logic             load;
  logic [3:0]       top;

  assign bcd_ready = (state == IDLE);
  assign slot_free = !out_valid || out_ready;
  assign load      = slot_free && (state == SIGN || state == DIGIT);
  assign top       = digits[BW-1 -: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (bcd_valid) begin
            digits <= bcd_in;
            neg    <= neg_in;
            cnt    <= CNT_W'(NDIG);
            state  <= SKIP;
          end
        end
        SKIP: begin
          // drop leading zeros, keep at least one digit
          if (top == 4'd0 && cnt != CNT_W'(1)) begin
            digits <= digits << 4;
            cnt    <= cnt - CNT_W'(1);
          end else begin
            state <= neg ? SIGN : DIGIT;
          end
        end
        SIGN: begin
          if (slot_free) begin
            out_char  <= CHAR_MINUS;
            out_last  <= 1'b0;
            state     <= DIGIT;
          end
        end
        DIGIT: begin
          if (slot_free) begin
            out_char  <= CHAR_ZERO + {2'b00, top};
            out_last  <= (cnt == CNT_W'(1));
            digits    <= digits << 4;
            cnt       <= cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// Converts one signed VALUE_BITS-bit integer per request into its decimal
// ASCII text, one character per output request, most significant first,
// with a leading '-' for negative values and the final character flagged
// by last_char. The magnitude runs through a bit-serial double-dabble
// converter, one input bit per cycle, which then hands the digits to the
// emitter; the emitter drops one leading zero per cycle (up to 9 at 32
// bits), then sends one character per cycle while the output side accepts.
// At 32 bits a request yields 1 to 11 characters; the next request is taken
// as soon as the converter has handed off its digits, so conversion
// overlaps with emission of the previous text.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input logic                   clk,
  input logic                   rst,
  sitda_value_if.sink           number,
  sitda_char_if.source          text
);
  import sitda_pkg::*;

  localparam int NDIG = dec_digits(VALUE_BITS);

  logic                bcd_valid;
  logic                bcd_ready;
  logic [NDIG*4-1:0]   bcd;
  logic                neg;

  sitda_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_dabble (
    .clk       (clk),
    .rst       (rst),
    .req_valid (number.valid),
    .req_ready (number.ready),
    .req_value (number.value),
    .bcd_valid (bcd_valid),
    .bcd_ready (bcd_ready),
    .bcd       (bcd),
    .neg       (neg)
  );

  sitda_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .bcd_valid (bcd_valid),
    .bcd_ready (bcd_ready),
    .bcd_in    (bcd),
    .neg_in    (neg),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_char  (text.char_code),
    .out_last  (text.last_char)
  );
endmodule

// File: verif/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
  import sitda_pkg::*;

  localparam int VALUE_BITS   = 32;
  localparam int RADIX        = 10;
  localparam int MAX_GAP      = 10;
  localparam int CHUNK_ITEMS  = 50;
  localparam int CHUNKS       = 6;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 100;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_PRINTS   = 30;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 last_char;
  } text_char_t;

  class decimal_text_scoreboard;
    text_char_t pending_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void queue_char(input text_char_t c);
      pending_chars = {pending_chars, c};
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("ERROR: %s", msg);
    endtask

    // expected text of one accepted number
    function void note_number(input logic [VALUE_BITS-1:0] v);
      logic [VALUE_BITS-1:0] mag;
      logic [3:0]            digits[$];
      text_char_t            c;
      mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
      do begin
        digits.push_front(4'(mag % RADIX));
        mag = mag / RADIX;
      end while (mag != 0);
      if (v[VALUE_BITS-1]) begin
        c.char_code = CHAR_MINUS;
        c.last_char = 1'b0;
        queue_char(c);
      end
      foreach (digits[i]) begin
        c.char_code = CHAR_ZERO + CHAR_BITS'(digits[i]);
        c.last_char = (i == digits.size() - 1);
        queue_char(c);
      end
    endfunction

    task check_char(input logic [CHAR_BITS-1:0] code, input logic last);
      text_char_t exp_c;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected character %0d last %0b", code, last));
      end else begin
        exp_c = pending_chars.pop_front();
        if (code !== exp_c.char_code)
          report($sformatf("char_code got %0d, expected %0d", code, exp_c.char_code));
        if (last !== exp_c.last_char)
          report($sformatf("last_char got %0b, expected %0b (char %0d)",
                           last, exp_c.last_char, exp_c.char_code));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic tx_burst;
  logic rx_burst;
  int   long_hold;
  int   cycles;

  decimal_text_scoreboard sb;

  sitda_value_if #(.VALUE_BITS(VALUE_BITS)) number_if ();
  sitda_char_if                              text_if ();

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .number (number_if),
    .text   (text_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_number(input logic [VALUE_BITS-1:0] v);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk);
      number_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    number_if.valid = 1'b1;
    number_if.value = v;
    do @(posedge clk); while (!number_if.ready);
    sb.note_number(v);
  endtask

  // lower the request and let every expected character come out
  task automatic drain();
    @(negedge clk);
    number_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] rand_number();
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] p;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 999);
      1: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * RADIX;
        v = p + $urandom_range(0, 2) - 1;
      end
      2: v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
      3: case ($urandom_range(0, 3))
        0: v = '0;
        1: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
        2: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
        default: v = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
      endcase
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // output side
  initial begin
    int gap;
    text_if.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (long_hold > 0) begin
        text_if.ready = 1'b0;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
      end
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        text_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      text_if.ready = 1'b1;
      do @(posedge clk); while (!text_if.valid);
      sb.check_char(text_if.char_code, text_if.last_char);
      @(negedge clk);
    end
  end

  initial begin
    logic [VALUE_BITS-1:0] directed[$];
    sb = new();
    cycles = 0;
    long_hold = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    number_if.valid = 1'b0;
    number_if.value = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7fffffff, 32'h80000000, 32'h80000001, 32'd1000000000,
      32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd1000000009,
      32'd12345, -32'sd6789, 32'h55555555, 32'haaaaaaaa, 32'h7ffffffe,
      -32'sd5, 32'd2000000000
    };
    foreach (directed[i]) send_number(directed[i]);

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk == 0) begin
        tx_burst = 1'b1;
        rx_burst = 1'b1;
      end else begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      if (chunk == 2) long_hold = LONG_HOLD;
      if (chunk == 4) drain();
      repeat (CHUNK_ITEMS) send_number(rand_number());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d characters never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
